/* sv/qts_pkg.sv */
`timescale 1ns / 1ps
// qts_pkg: types, codes and helpers shared by the quoted token splitter.
// No dependencies.
package qts_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic CFG_HIGH_SEP = 1'b0;
    localparam logic CFG_COMMENTS = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_COMM  = 3'd2,
        MODE_PLAIN = 3'd3,
        MODE_QUOTE = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] token_char;
        logic       from_quotes;
        logic       run_last;
    } t_out_beat;

    typedef struct packed {
        logic high_bytes_separate;
        logic comments_enabled;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_beat  r0;
        t_out_beat  r1;
    } t_scan_res;

    function automatic logic is_sep(input logic [7:0] b, input logic hi_sep);
        return (b <= CH_SPACE) || (b[7] && hi_sep);
    endfunction

    function automatic t_out_beat mk_beat(input logic kind, input logic [7:0] ch,
                                          input logic q);
        t_out_beat r;
        r.item_kind   = kind;
        r.token_char  = (kind == KIND_END) ? CH_NUL : ch;
        r.from_quotes = q;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

/* sv/qts_scan.sv */
`timescale 1ns / 1ps
// qts_scan: scan state register and per-byte decode into up to two results.
// Depends on qts_pkg.
module qts_scan
    import qts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    output t_scan_res o_res
);

    t_mode     r_mode, n_mode;
    logic      r_quote, n_quote;
    t_scan_res res;
    logic      sep;
    logic [7:0] b;

    assign b   = i_beat.text_byte;
    assign sep = is_sep(b, i_cfg.high_bytes_separate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_quote <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_quote = r_quote;
        res.cnt = 2'd0;
        res.r0  = mk_beat(KIND_END, CH_NUL, 1'b0);
        res.r1  = mk_beat(KIND_END, CH_NUL, 1'b0);
        if (i_beat.end_of_text) begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    res.cnt = 2'd1;
                end
                MODE_QUOTE: begin
                    res.cnt = 2'd1;
                    res.r0  = mk_beat(KIND_END, CH_NUL, 1'b1);
                end
                MODE_SLASH: begin
                    res.cnt = 2'd2;
                    res.r0  = mk_beat(KIND_BYTE, CH_SLASH, 1'b0);
                end
                default: ;
            endcase
            n_mode  = MODE_IDLE;
            n_quote = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_SLASH: begin
                    if (i_cfg.comments_enabled && b == CH_SLASH) begin
                        n_mode = MODE_COMM;
                    end else begin
                        res.cnt = 2'd2;
                        res.r0  = mk_beat(KIND_BYTE, CH_SLASH, 1'b0);
                        if (sep) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            res.r1 = mk_beat(KIND_BYTE, b, 1'b0);
                            n_mode = MODE_PLAIN;
                        end
                    end
                end
                MODE_COMM: begin
                    if (b == CH_NL) n_mode = MODE_IDLE;
                end
                MODE_PLAIN: begin
                    res.cnt = 2'd1;
                    if (sep) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        res.r0 = mk_beat(KIND_BYTE, b, 1'b0);
                    end
                end
                MODE_QUOTE: begin
                    res.cnt = 2'd1;
                    if (b == CH_NUL || b == (r_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                        res.r0 = mk_beat(KIND_END, CH_NUL, 1'b1);
                        n_mode = MODE_IDLE;
                    end else begin
                        res.r0 = mk_beat(KIND_BYTE, b, 1'b1);
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (sep) begin
                        n_mode = MODE_IDLE;
                    end else if (b == CH_SLASH && i_cfg.comments_enabled) begin
                        n_mode = MODE_SLASH;
                    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        n_quote = (b == CH_SQUOTE);
                        n_mode  = MODE_QUOTE;
                    end else begin
                        res.cnt = 2'd1;
                        res.r0  = mk_beat(KIND_BYTE, b, 1'b0);
                        n_mode  = MODE_PLAIN;
                    end
                end
            endcase
        end
        if (res.cnt == 2'd1) res.r0.run_last = 1'b1;
        if (res.cnt == 2'd2) res.r1.run_last = 1'b1;
        if (!i_accept) res.cnt = 2'd0;
    end

    assign o_res = res;

`ifndef ASSERT_OFF
    a_two_only_from_slash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.cnt == 2'd2 |-> r_mode == MODE_SLASH)
        else $error("two results outside held slash");
    a_eot_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_beat.end_of_text) |=> (r_mode == MODE_IDLE && !r_quote))
        else $error("end of text did not return to idle");
    a_comment_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_COMM |-> o_res.cnt == 2'd0)
        else $error("result emitted inside comment");
`endif

endmodule

/* sv/qts_outq.sv */
`timescale 1ns / 1ps
// qts_outq: small result queue, up to two writes and one read per cycle, reads held by i_stall.
// Depends on qts_pkg.
module qts_outq
    import qts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_res i_res,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_out_beat             r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic [QUEUE_AW-1:0]   wr1;
    logic                  pop;

    assign wr1     = r_wr + QUEUE_AW'(1);
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_full  = (r_count > QUEUE_CW'(QUEUE_DEPTH - 2));
    assign n_count = r_count + QUEUE_CW'(i_res.cnt) - QUEUE_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_res.cnt != 2'd0) r_q[r_wr] <= i_res.r0;
        if (i_res.cnt == 2'd2) r_q[wr1]  <= i_res.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QUEUE_AW'(i_res.cnt);
            r_rd    <= r_rd + QUEUE_AW'(pop);
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.cnt != 2'd0 |-> r_count + QUEUE_CW'(i_res.cnt) <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && i_res.cnt != 2'd0) |=> o_valid)
        else $error("pushed result not presented");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

/* sv/quoted_token_splitter_core.sv */
`timescale 1ns / 1ps
// quoted_token_splitter_core: top level, configuration registers, scanner and result queue.
// Depends on qts_pkg, qts_scan, qts_outq.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle unless stalled; it gives zero, one or two result beats.
// Results of an accepted byte are registered in the queue, shown once earlier ones are read.
// The four-entry result queue sets the rate: stall rises once fewer than
// two entries are free, so bytes yielding two results run at the output rate.
// Reset is synchronous and returns to idle between tokens with both options on.
module quoted_token_splitter_core
    import qts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic      i_cfg_data
);

    t_cfg      r_cfg;
    t_scan_res res;
    logic      full;
    logic      accept;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_bytes_separate <= 1'b1;
            r_cfg.comments_enabled    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HIGH_SEP: r_cfg.high_bytes_separate <= i_cfg_data;
                CFG_COMMENTS: r_cfg.comments_enabled    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_beat  (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    qts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
